// ----- hdl/swm_pkg.sv -----
// shared types and constants of the sliding window median filter
package swm_pkg;

    // configuration register file
    localparam int WS_WIDTH       = 7;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam logic [WS_WIDTH-1:0] WS_RESET = 7'd3;
    // register index as seen in paddr[2]
    localparam logic REG_IDX_WINDOW_SIZE = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PICK,
        ST_ADD,
        ST_OUT
    } t_swm_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic load;     // apply remove and insert this cycle
        logic full;     // window is full, the oldest sample leaves
    } t_row_ctrl;

    // flags a cell hands to its neighbors
    typedef struct packed {
        logic a;        // at or after the removed slot (or beyond the live range)
        logic g;        // greater than the new sample (or beyond the live range)
    } t_cell_flags;

endpackage

// ----- hdl/swm_cell.sv -----
// one cell of the sorted row: holds one window value and shifts with its neighbors
module swm_cell #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  swm_pkg::t_row_ctrl             i_ctrl,
    input  logic                           i_beyond,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_old,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_value,
    input  swm_pkg::t_cell_flags           i_left_flags,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  swm_pkg::t_cell_flags           i_right_flags,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output swm_pkg::t_cell_flags           o_flags
);
    import swm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic signed [SAMPLE_WIDTH-1:0] w_rem_left;
    logic signed [SAMPLE_WIDTH-1:0] w_rem_own;
    logic                           w_rg_left;
    logic                           w_rg_own;

    // own flags against the new sample and the leaving sample
    assign o_flags.g = i_beyond | (r_value > i_sample);
    assign o_flags.a = i_beyond | (i_ctrl.full & (r_value >= i_old));
    assign o_value   = r_value;

    // values after removal at the left neighbor and here, then insertion
    always_comb begin
        w_rem_left = i_left_flags.a ? r_value : i_left_value;
        w_rem_own  = o_flags.a ? i_right_value : r_value;
        w_rg_left  = i_left_flags.a ? o_flags.g : i_left_flags.g;
        w_rg_own   = o_flags.a ? i_right_flags.g : o_flags.g;
        if (w_rg_left) begin
            n_value = w_rem_left;
        end else if (w_rg_own) begin
            n_value = i_sample;
        end else begin
            n_value = w_rem_own;
        end
    end

    // value register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= n_value;
        end
    end

endmodule

// ----- hdl/swm_cell_row.sv -----
// row of sorting cells, the window contents in ascending order
module swm_cell_row #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32,
    parameter int COUNT_WIDTH  = 7
) (
    input  logic                           i_clk,
    input  swm_pkg::t_row_ctrl             i_ctrl,
    input  logic [COUNT_WIDTH-1:0]         i_limit,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] i_old,
    output logic signed [SAMPLE_WIDTH-1:0] o_values [WINDOW_MAX]
);
    import swm_pkg::*;

    t_cell_flags w_flags [WINDOW_MAX];

    // cells at or past the live range count as plus infinity
    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] w_left_value;
        logic signed [SAMPLE_WIDTH-1:0] w_right_value;
        t_cell_flags                    w_left_flags;
        t_cell_flags                    w_right_flags;
        logic                           w_beyond;

        assign w_beyond = (COUNT_WIDTH'(j) >= i_limit);

        if (j == 0) begin : g_left_edge
            assign w_left_value = '0;
            assign w_left_flags = '{a: 1'b0, g: 1'b0};
        end else begin : g_left_link
            assign w_left_value = o_values[j-1];
            assign w_left_flags = w_flags[j-1];
        end

        if (j == WINDOW_MAX - 1) begin : g_right_edge
            assign w_right_value = '0;
            assign w_right_flags = '{a: 1'b1, g: 1'b1};
        end else begin : g_right_link
            assign w_right_value = o_values[j+1];
            assign w_right_flags = w_flags[j+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_beyond     (w_beyond),
            .i_sample     (i_sample),
            .i_old        (i_old),
            .i_left_value (w_left_value),
            .i_left_flags (w_left_flags),
            .i_right_value(w_right_value),
            .i_right_flags(w_right_flags),
            .o_value      (o_values[j]),
            .o_flags      (w_flags[j])
        );
    end

endmodule

// ----- hdl/sliding_window_median.sv -----
// Sliding window median filter. Each sample on the input stream (tlast ends a run and empties
// the window after that sample) enters a ring memory in arrival order and a row of sorting
// cells that keep the window in ascending order; in the update step the cells drop the oldest
// sample (once the window is full) and take the new one at its sorted place. Once the window
// holds window_size samples, each sample gives one median: the middle value for an odd window,
// the two middle values summed at SAMPLE_WIDTH+1 bits and halved toward zero for an even one.
// A sample goes through accept and cell update when it gives no result, and through accept,
// cell update, middle select, add and output load when it does; the output load step waits
// as long as the previous result is still held off on the result stream, and the next sample
// is taken while a result waits in the output register. Writing window_size (0 acts as 1,
// values above WINDOW_MAX saturate) empties the window.
module sliding_window_median #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // input stream
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        i_s_tdata,  // [SW-1:0] sample
    input  logic                                     i_s_tlast,  // end_of_run
    // result stream
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        o_m_tdata,  // [SW-1:0] median
    // configuration port
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [swm_pkg::APB_ADDR_WIDTH-1:0]       paddr,
    input  logic [swm_pkg::APB_DATA_WIDTH-1:0]       pwdata,
    output logic [swm_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                     pready
);
    import swm_pkg::*;

    localparam int DATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int COUNT_WIDTH = $clog2(WINDOW_MAX + 1);
    localparam int PTR_WIDTH   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > WS_WIDTH) ? COUNT_WIDTH : WS_WIDTH;

    t_swm_state                     r_state;
    t_swm_state                     n_state;
    logic [WS_WIDTH-1:0]            r_window_size;
    logic [COUNT_WIDTH-1:0]         r_fill;
    logic [PTR_WIDTH-1:0]           r_ptr;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic                           r_last;
    logic signed [SAMPLE_WIDTH-1:0] r_old;
    logic [SAMPLE_WIDTH-1:0]        r_lo;
    logic [SAMPLE_WIDTH-1:0]        r_hi;
    logic [SAMPLE_WIDTH:0]          r_sum;
    logic [SAMPLE_WIDTH-1:0]        r_median;
    logic                           r_m_tvalid;
    logic signed [SAMPLE_WIDTH-1:0] r_ring [WINDOW_MAX];

    logic                           w_s_accept;
    logic                           w_cfg_write;
    logic [CMP_WIDTH-1:0]           w_ws_ext;
    logic [COUNT_WIDTH-1:0]         w_win;
    logic                           w_full;
    logic [COUNT_WIDTH-1:0]         w_limit;
    logic [COUNT_WIDTH-1:0]         w_fill_inc;
    logic [COUNT_WIDTH-1:0]         w_ptr_inc;
    logic                           w_produce;
    logic                           w_out_load;
    logic [PTR_WIDTH-1:0]           w_hi_idx;
    logic [PTR_WIDTH-1:0]           w_lo_idx;
    logic [PTR_WIDTH-1:0]           w_wr_addr;
    t_row_ctrl                      w_row_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] w_values [WINDOW_MAX];

    // handshakes
    assign w_s_accept  = i_s_tvalid & o_s_tready;
    assign pready      = 1'b1;
    assign w_cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_WINDOW_SIZE);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
        end else if (w_cfg_write) begin
            r_window_size <= pwdata[WS_WIDTH-1:0];
        end
    end

    // register read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_WINDOW_SIZE) begin
            prdata = APB_DATA_WIDTH'(r_window_size);
        end
    end

    // effective window size
    always_comb begin
        w_ws_ext = CMP_WIDTH'(r_window_size);
        if (w_ws_ext == '0) begin
            w_win = COUNT_WIDTH'(1);
        end else if (w_ws_ext > CMP_WIDTH'(WINDOW_MAX)) begin
            w_win = COUNT_WIDTH'(WINDOW_MAX);
        end else begin
            w_win = w_ws_ext[COUNT_WIDTH-1:0];
        end
    end

    // window bookkeeping
    assign w_full     = (r_fill == w_win);
    assign w_limit    = w_full ? w_win : r_fill;
    assign w_fill_inc = r_fill + COUNT_WIDTH'(1);
    assign w_ptr_inc  = COUNT_WIDTH'(r_ptr) + COUNT_WIDTH'(1);
    assign w_produce  = w_full | (w_fill_inc == w_win);
    assign w_wr_addr  = w_full ? r_ptr : r_fill[PTR_WIDTH-1:0];
    assign w_hi_idx   = PTR_WIDTH'(w_win >> 1);
    assign w_lo_idx   = w_hi_idx - PTR_WIDTH'(1);

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and controls
    always_comb begin
        n_state         = r_state;
        o_s_tready      = 1'b0;
        w_out_load      = 1'b0;
        w_row_ctrl.load = 1'b0;
        w_row_ctrl.full = w_full;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                w_row_ctrl.load = 1'b1;
                n_state = w_produce ? ST_PICK : ST_IDLE;
            end
            ST_PICK: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // fill count and oldest slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (w_cfg_write) begin
            r_fill <= '0;
            r_ptr  <= '0;
        end else if (r_state == ST_UPDATE) begin
            if (r_last) begin
                r_fill <= '0;
                r_ptr  <= '0;
            end else if (w_full) begin
                r_ptr <= (w_ptr_inc >= w_win) ? '0 : w_ptr_inc[PTR_WIDTH-1:0];
            end else begin
                r_fill <= w_fill_inc;
            end
        end
    end

    // accepted transaction and the sample it displaces
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_sample <= i_s_tdata[SAMPLE_WIDTH-1:0];
            r_last   <= i_s_tlast;
            r_old    <= r_ring[r_ptr];
        end
    end

    // arrival order ring
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_ring[w_wr_addr] <= r_sample;
        end
    end

    // sorted row
    swm_cell_row #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_row (
        .i_clk   (i_clk),
        .i_ctrl  (w_row_ctrl),
        .i_limit (w_limit),
        .i_sample(r_sample),
        .i_old   (r_old),
        .o_values(w_values)
    );

    // middle values, then their sum (odd window doubles the middle value)
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PICK) begin
            r_hi <= w_values[w_hi_idx];
            r_lo <= w_values[w_lo_idx];
        end
        if (r_state == ST_ADD) begin
            if (w_win[0]) begin
                r_sum <= {r_hi, 1'b0};
            end else begin
                r_sum <= {r_lo[SAMPLE_WIDTH-1], r_lo} + {r_hi[SAMPLE_WIDTH-1], r_hi};
            end
        end
    end

    // output register, halving toward zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_median <= r_sum[SAMPLE_WIDTH:1] + SAMPLE_WIDTH'(r_sum[SAMPLE_WIDTH] & r_sum[0]);
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = DATA_WIDTH'(r_median);

    // fill count never passes the window size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_win)
        else $error("fill count above window size");

    // oldest slot stays inside a full window
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> (COUNT_WIDTH'(r_ptr) < w_win))
        else $error("oldest slot outside window");

    // end of run empties the window after its update
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_accept && i_s_tlast) |=> ##1 (r_fill == '0 && r_ptr == '0))
        else $error("window not emptied at end of run");

    // a result appears only from the output load step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside output step");

endmodule
